// ===== rtl/pwm_pulse_pair_decoder_crc8_defines.svh =====
// assertion macros for the pulse pair decoder
`ifndef PWM_PULSE_PAIR_DECODER_CRC8_DEFINES_SVH
`define PWM_PULSE_PAIR_DECODER_CRC8_DEFINES_SVH

`ifndef SYNTH
`define PPD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define PPD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define PPD_ASSERT(name, clk, rst_n, prop)
`define PPD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== rtl/ppd_pkg.sv =====
package ppd_pkg;

    localparam int TimeW   = 16;
    localparam int CountW  = 7;
    localparam int StatusW = 2;
    localparam int IdW     = 16;
    localparam int RawW    = 40;
    localparam int ShiftW  = 64;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 16;
    localparam int CrcMsgW = 32;
    localparam int GapW    = TimeW + 2;

    localparam logic [7:0] CrcPoly = 8'h07;
    localparam logic [7:0] CrcInit = 8'h00;

    localparam logic [TimeW-1:0]  ShortPeriodReset = 16'd800;
    localparam logic [TimeW-1:0]  LongPeriodReset  = 16'd1750;
    localparam logic [TimeW-1:0]  ToleranceReset   = 16'd200;
    localparam logic [CountW-1:0] BitsNeededReset  = 7'd40;
    localparam logic [CountW-1:0] CountMax         = '1;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_BAD_PAIR = 2'd2,
        ST_SHORT    = 2'd3
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SHORT_PERIOD = 2'd0,
        CFG_LONG_PERIOD  = 2'd1,
        CFG_TOLERANCE    = 2'd2,
        CFG_BITS_NEEDED  = 2'd3
    } t_cfg_reg;

    typedef logic [7:0] t_crc_weights [CrcMsgW];

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    // crc contribution of each single message bit, msb first
    function automatic t_crc_weights crc8_weights();
        t_crc_weights w;
        logic [7:0]   crc;
        logic         fb;
        for (int j = 0; j < CrcMsgW; j++) begin
            crc = CrcInit;
            for (int k = CrcMsgW - 1; k >= 0; k--) begin
                fb  = crc[7] ^ (k == j);
                crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
            end
            w[j] = crc;
        end
        return w;
    endfunction

    localparam t_crc_weights CrcWeights = crc8_weights();

    function automatic logic [7:0] crc8_msg(input logic [CrcMsgW-1:0] m);
        logic [7:0] x;
        x = CrcInit;
        for (int j = 0; j < CrcMsgW; j++) begin
            x = x ^ (m[j] ? CrcWeights[j] : 8'h00);
        end
        return x;
    endfunction

    function automatic logic near_to(
        input logic [TimeW-1:0] t,
        input logic [TimeW-1:0] nominal,
        input logic [TimeW-1:0] tol
    );
        logic [TimeW-1:0] d;
        d = (t > nominal) ? (t - nominal) : (nominal - t);
        return d < tol;
    endfunction

endpackage

// ===== rtl/pwm_pulse_pair_decoder_crc8.sv =====
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall    high_time, low_time, first_pair, last_pair
// out       output     o_out_valid / i_out_stall  status, sensor_id, raw_bits, bit_count
// cfg       input      i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// one request per cycle while o_in_stall is low; a pair is taken into the input
// register, decoded from there and its result loaded into the result register
// the decode, shift and crc check sit between the input and result registers
// reset is synchronous, active low; the decoder then waits for a first pair
// o_in_stall rises only when both the input and the result register are full
// and i_out_stall is high
`include "pwm_pulse_pair_decoder_crc8_defines.svh"

module pwm_pulse_pair_decoder_crc8 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ppd_pkg::TimeW-1:0]     i_high_time,
    input  logic [ppd_pkg::TimeW-1:0]     i_low_time,
    input  logic                          i_first_pair,
    input  logic                          i_last_pair,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ppd_pkg::StatusW-1:0]   o_status,
    output logic [ppd_pkg::IdW-1:0]       o_sensor_id,
    output logic [ppd_pkg::RawW-1:0]      o_raw_bits,
    output logic [ppd_pkg::CountW-1:0]    o_bit_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ppd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [ppd_pkg::CfgW-1:0]      i_cfg_data
);
    import ppd_pkg::*;

    logic [TimeW-1:0]  r_short_period;
    logic [TimeW-1:0]  r_long_period;
    logic [TimeW-1:0]  r_tolerance;
    logic [CountW-1:0] r_bits_needed;

    logic              r_in_valid;
    logic [TimeW-1:0]  r_high_time;
    logic [TimeW-1:0]  r_low_time;
    logic              r_first_pair;
    logic              r_last_pair;

    logic [ShiftW-1:0] r_shift;
    logic [CountW-1:0] r_seen;
    logic              r_done;

    logic              r_out_valid;
    t_status           r_status;
    logic [IdW-1:0]    r_sensor_id;
    logic [RawW-1:0]   r_raw_bits;
    logic [CountW-1:0] r_bit_count;

    logic              out_free;
    logic              proceed;
    logic              has_result;
    t_status           n_status;
    logic [IdW-1:0]    n_sensor_id;
    logic [ShiftW-1:0] n_shift;
    logic [CountW-1:0] n_seen;
    logic              n_done;

    logic [ShiftW-1:0] st_shift;
    logic [CountW-1:0] st_seen;
    logic              st_done;
    logic [GapW-1:0]   gap;
    logic [CountW-1:0] need;
    logic              hi_long;
    logic              hi_short;
    logic              lo_long;
    logic              lo_short;
    logic              lo_gap;
    logic              bit_ok;
    logic              bit_val;
    logic [7:0]        msg [5];

    assign out_free    = !r_out_valid || !i_out_stall;
    assign proceed     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_sensor_id = r_sensor_id;
    assign o_raw_bits  = r_raw_bits;
    assign o_bit_count = r_bit_count;

    always_comb begin
        st_shift = r_first_pair ? '0 : r_shift;
        st_seen  = r_first_pair ? '0 : r_seen;
        st_done  = r_first_pair ? 1'b0 : r_done;

        gap  = {2'b00, r_long_period} + {1'b0, r_long_period, 1'b0};
        need = (r_bits_needed == '0) ? CountW'(1) : r_bits_needed;

        hi_long  = near_to(r_high_time, r_long_period, r_tolerance);
        hi_short = near_to(r_high_time, r_short_period, r_tolerance);
        lo_long  = near_to(r_low_time, r_long_period, r_tolerance);
        lo_short = near_to(r_low_time, r_short_period, r_tolerance);
        lo_gap   = {2'b00, r_low_time} > gap;

        bit_ok  = 1'b1;
        bit_val = 1'b0;
        if (hi_long && lo_short) begin
            bit_val = 1'b1;
        end else if (hi_short && lo_long) begin
            bit_val = 1'b0;
        end else if (hi_short && lo_gap) begin
            bit_val = 1'b0;
        end else if (hi_long && lo_gap) begin
            bit_val = 1'b1;
        end else begin
            bit_ok = 1'b0;
        end

        n_shift     = st_shift;
        n_seen      = st_seen;
        n_done      = st_done;
        has_result  = 1'b0;
        n_status    = ST_OK;
        n_sensor_id = '0;

        if (bit_ok) begin
            n_shift = {st_shift[ShiftW-2:0], bit_val};
            n_seen  = (st_seen == CountMax) ? st_seen : st_seen + CountW'(1);
        end

        for (int i = 0; i < 5; i++) begin
            msg[i] = rev8(n_shift[RawW-1-8*i -: 8]);
        end

        if (!st_done) begin
            if (!bit_ok) begin
                n_done     = 1'b1;
                has_result = 1'b1;
                n_status   = ST_BAD_PAIR;
            end else if (n_seen >= need) begin
                n_done     = 1'b1;
                has_result = 1'b1;
                if (crc8_msg({msg[0], msg[1], msg[2], msg[3]}) != msg[4]) begin
                    n_status = ST_CRC_ERR;
                end else begin
                    n_status    = ST_OK;
                    n_sensor_id = {msg[1], msg[2]};
                end
            end else if (r_last_pair) begin
                n_done     = 1'b1;
                has_result = 1'b1;
                n_status   = ST_SHORT;
            end
        end else begin
            // waiting for a first pair: nothing changes
            n_shift = r_shift;
            n_seen  = r_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_period <= ShortPeriodReset;
            r_long_period  <= LongPeriodReset;
            r_tolerance    <= ToleranceReset;
            r_bits_needed  <= BitsNeededReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SHORT_PERIOD: r_short_period <= i_cfg_data;
                CFG_LONG_PERIOD:  r_long_period  <= i_cfg_data;
                CFG_TOLERANCE:    r_tolerance    <= i_cfg_data;
                CFG_BITS_NEEDED:  r_bits_needed  <= i_cfg_data[CountW-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_high_time  <= i_high_time;
            r_low_time   <= i_low_time;
            r_first_pair <= i_first_pair;
            r_last_pair  <= i_last_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_seen  <= '0;
            r_done  <= 1'b1;
        end else if (proceed) begin
            r_shift <= n_shift;
            r_seen  <= n_seen;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proceed && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && has_result) begin
            r_status    <= n_status;
            r_sensor_id <= n_sensor_id;
            r_raw_bits  <= n_shift[RawW-1:0];
            r_bit_count <= n_seen;
        end
    end

    `PPD_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
    `PPD_ASSERT(a_id_zero_unless_ok, i_clk, i_rst_n, (r_out_valid && r_status != ST_OK) |-> (r_sensor_id == '0))
    `PPD_ASSERT(a_result_ends_capture, i_clk, i_rst_n, (proceed && has_result) |=> r_done)
    `PPD_ASSERT(a_new_result_loads, i_clk, i_rst_n, (proceed && has_result) |=> r_out_valid)

endmodule
